### sv/cnfr_pkg.sv
// Package with shared types, constants and functions of the friend recommender.
package cnfr_pkg;

   localparam int MAX_USERS = 64;
   localparam int IDX_W     = $clog2(MAX_USERS);
   localparam int FIELD_IDX_W = 6;
   localparam int ROW_W     = 64;
   localparam int ID_W      = 31;
   localparam int COUNT_W   = 7;
   localparam int STATUS_W  = 2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic                   opcode;
      logic [FIELD_IDX_W-1:0] user_index;
      logic [ROW_W-1:0]       adjacency_row;
      logic [ID_W-1:0]        user_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     recommended_id;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QROW,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Bit j set for every user below the effective count.
   function automatic logic [ROW_W-1:0] live_mask(input logic [COUNT_W-1:0] n);
      logic [ROW_W-1:0] m;
      for (int j = 0; j < ROW_W; j++) begin
         m[j] = (COUNT_W'(j) < n);
      end
      return m;
   endfunction

   function automatic logic [3:0] count8(input logic [7:0] v);
      logic [3:0] c;
      c = 4'd0;
      for (int j = 0; j < 8; j++) begin
         c = c + 4'(v[j]);
      end
      return c;
   endfunction

   function automatic logic [COUNT_W-1:0] count64(input logic [ROW_W-1:0] v);
      logic [COUNT_W-1:0] c;
      c = '0;
      for (int b = 0; b < ROW_W / 8; b++) begin
         c = c + COUNT_W'(count8(v[b*8 +: 8]));
      end
      return c;
   endfunction

endpackage

### sv/cnfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cnfr_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/common_neighbor_friend_recommender_unit.sv
// Top level of the common-neighbor friend recommender: control, scan pipeline and stores.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | cnfr_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_stall | cnfr_pkg::rsp_type
//  csr     | in        | csr_valid/csr_ready | user_count, 7 bits
//
// A load is written from idle. A query for effective user count n holds off the next request
// through the querying-row read, the n row reads, the drain and pick, and the send.
// Out-of-range queries go straight to the send; queries with no candidate end after the row read.
// Reset clears control only; the stores hold garbage until loaded.
// A stalled result waits in the output register while the next request is taken;
// a finished query waits in the result register until the output register is free.
module common_neighbor_friend_recommender_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  cnfr_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output cnfr_pkg::rsp_type                rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cnfr_pkg::COUNT_W-1:0]     csr_data
);

   cnfr_pkg::state_type state_ff, state_in;

   logic [cnfr_pkg::COUNT_W-1:0] user_count_ff;
   logic [cnfr_pkg::IDX_W-1:0]   q_ff, q_in;
   logic [cnfr_pkg::ROW_W-1:0]   rowq_ff, rowq_in;
   logic [cnfr_pkg::ROW_W-1:0]   cand_ff, cand_in;
   logic [cnfr_pkg::IDX_W-1:0]   scan_idx_ff, scan_idx_in;

   logic                         s1_valid_ff, s1_valid_in;
   logic [cnfr_pkg::IDX_W-1:0]   s1_idx_ff, s1_idx_in;
   logic                         s2_valid_ff, s2_valid_in;
   logic [cnfr_pkg::COUNT_W-1:0] s2_c_ff, s2_c_in;
   logic [cnfr_pkg::COUNT_W-1:0] s2_d_ff, s2_d_in;
   logic [cnfr_pkg::ID_W-1:0]    s2_id_ff;

   logic                         have_c_ff, have_c_in;
   logic [cnfr_pkg::COUNT_W-1:0] best_c_ff, best_c_in;
   logic [cnfr_pkg::ID_W-1:0]    id_c_ff, id_c_in;
   logic                         have_d_ff, have_d_in;
   logic [cnfr_pkg::COUNT_W-1:0] best_d_ff, best_d_in;
   logic [cnfr_pkg::ID_W-1:0]    id_d_ff, id_d_in;

   cnfr_pkg::rsp_type res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cnfr_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   logic                         clear_best;
   logic                         wr_en;
   logic [cnfr_pkg::IDX_W-1:0]   rd_addr;
   logic [cnfr_pkg::ROW_W-1:0]   adj_rdata;
   logic [cnfr_pkg::ID_W-1:0]    id_rdata;

   logic [cnfr_pkg::COUNT_W-1:0] n_w;
   logic [cnfr_pkg::ROW_W-1:0]   live_w;
   logic [cnfr_pkg::COUNT_W-1:0] req_idx_w;
   logic [cnfr_pkg::ROW_W-1:0]   rowq_live_w;
   logic [cnfr_pkg::ROW_W-1:0]   qbit_w;
   logic [cnfr_pkg::ROW_W-1:0]   rowi_w;
   logic [cnfr_pkg::ROW_W-1:0]   self_w;

   assign n_w = (user_count_ff > cnfr_pkg::COUNT_W'(cnfr_pkg::MAX_USERS)) ?
                cnfr_pkg::COUNT_W'(cnfr_pkg::MAX_USERS) : user_count_ff;
   assign live_w      = cnfr_pkg::live_mask(n_w);
   assign req_idx_w   = cnfr_pkg::COUNT_W'(req_payload.user_index);
   assign rowq_live_w = adj_rdata & live_w;
   assign qbit_w      = cnfr_pkg::ROW_W'(1) << q_ff;

   assign req_stall = (state_ff != cnfr_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   cnfr_ram #(
      .WIDTH (cnfr_pkg::ROW_W),
      .DEPTH (cnfr_pkg::MAX_USERS)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_payload.user_index[cnfr_pkg::IDX_W-1:0]),
      .wr_data (req_payload.adjacency_row),
      .rd_addr (rd_addr),
      .rd_data (adj_rdata)
   );

   cnfr_ram #(
      .WIDTH (cnfr_pkg::ID_W),
      .DEPTH (cnfr_pkg::MAX_USERS)
   ) u_id_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_payload.user_index[cnfr_pkg::IDX_W-1:0]),
      .wr_data (req_payload.user_id),
      .rd_addr (rd_addr),
      .rd_data (id_rdata)
   );

   // Sequencer and output register.
   always_comb begin
      state_in       = state_ff;
      q_in           = q_ff;
      rowq_in        = rowq_ff;
      cand_in        = cand_ff;
      scan_idx_in    = scan_idx_ff;
      s1_valid_in    = 1'b0;
      s1_idx_in      = scan_idx_ff;
      res_in         = res_ff;
      clear_best     = 1'b0;
      wr_en          = 1'b0;
      rd_addr        = scan_idx_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      case (state_ff)
         cnfr_pkg::ST_IDLE: begin
            rd_addr = req_payload.user_index[cnfr_pkg::IDX_W-1:0];
            if (req_valid) begin
               if (req_payload.opcode == cnfr_pkg::OP_LOAD) begin
                  wr_en = (req_idx_w < cnfr_pkg::COUNT_W'(cnfr_pkg::MAX_USERS));
               end else begin
                  q_in = req_payload.user_index[cnfr_pkg::IDX_W-1:0];
                  if (req_idx_w < n_w) begin
                     state_in = cnfr_pkg::ST_QROW;
                  end else begin
                     res_in.status         = cnfr_pkg::STATUS_RANGE;
                     res_in.recommended_id = '0;
                     state_in              = cnfr_pkg::ST_FINISH;
                  end
               end
            end
         end
         cnfr_pkg::ST_QROW: begin
            rowq_in     = rowq_live_w;
            cand_in     = ~rowq_live_w & live_w & ~qbit_w;
            clear_best  = 1'b1;
            scan_idx_in = '0;
            if (cand_in == '0) begin
               res_in.status         = cnfr_pkg::STATUS_NONE;
               res_in.recommended_id = '0;
               state_in              = cnfr_pkg::ST_FINISH;
            end else begin
               state_in = cnfr_pkg::ST_SCAN;
            end
         end
         cnfr_pkg::ST_SCAN: begin
            s1_valid_in = 1'b1;
            if (cnfr_pkg::COUNT_W'(scan_idx_ff) == n_w - cnfr_pkg::COUNT_W'(1)) begin
               state_in = cnfr_pkg::ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + cnfr_pkg::IDX_W'(1);
            end
         end
         cnfr_pkg::ST_DRAIN: begin
            // wait for the last row to leave the pipeline
            if (!s1_valid_ff && !s2_valid_ff) begin
               res_in.status         = cnfr_pkg::STATUS_OK;
               res_in.recommended_id = have_c_ff ? id_c_ff : id_d_ff;
               state_in              = cnfr_pkg::ST_FINISH;
            end
         end
         cnfr_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = res_ff;
               state_in       = cnfr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cnfr_pkg::ST_IDLE;
         end
      endcase
   end

   // Stage 1: count common neighbors and degree of the row just read.
   always_comb begin
      self_w      = cnfr_pkg::ROW_W'(1) << s1_idx_ff;
      rowi_w      = adj_rdata & live_w;
      s2_valid_in = s1_valid_ff && cand_ff[s1_idx_ff];
      s2_c_in     = cnfr_pkg::count64(rowq_ff & rowi_w & ~self_w & ~qbit_w);
      s2_d_in     = cnfr_pkg::count64(rowi_w & ~self_w);
   end

   // Stage 2: keep the best candidate by each score; smaller ID wins a tie.
   always_comb begin
      have_c_in = have_c_ff;
      best_c_in = best_c_ff;
      id_c_in   = id_c_ff;
      have_d_in = have_d_ff;
      best_d_in = best_d_ff;
      id_d_in   = id_d_ff;
      if (clear_best) begin
         have_c_in = 1'b0;
         have_d_in = 1'b0;
      end else if (s2_valid_ff) begin
         if (s2_c_ff != '0 && (!have_c_ff || s2_c_ff > best_c_ff ||
             (s2_c_ff == best_c_ff && s2_id_ff < id_c_ff))) begin
            have_c_in = 1'b1;
            best_c_in = s2_c_ff;
            id_c_in   = s2_id_ff;
         end
         if (!have_d_ff || s2_d_ff > best_d_ff ||
             (s2_d_ff == best_d_ff && s2_id_ff < id_d_ff)) begin
            have_d_in = 1'b1;
            best_d_in = s2_d_ff;
            id_d_in   = s2_id_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cnfr_pkg::ST_IDLE;
         user_count_ff <= cnfr_pkg::COUNT_W'(cnfr_pkg::MAX_USERS);
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         have_c_ff     <= 1'b0;
         have_d_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         have_c_ff    <= have_c_in;
         have_d_ff    <= have_d_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            user_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff           <= q_in;
      rowq_ff        <= rowq_in;
      cand_ff        <= cand_in;
      scan_idx_ff    <= scan_idx_in;
      s1_idx_ff      <= s1_idx_in;
      s2_c_ff        <= s2_c_in;
      s2_d_ff        <= s2_d_in;
      s2_id_ff       <= id_rdata;
      best_c_ff      <= best_c_in;
      id_c_ff        <= id_c_in;
      best_d_ff      <= best_d_in;
      id_d_ff        <= id_d_in;
      res_ff         <= res_in;
      rsp_payload_ff <= rsp_payload_in;
   end

`ifndef SYNTHESIS
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cnfr_pkg::ST_SCAN) |-> (cnfr_pkg::COUNT_W'(scan_idx_ff) < n_w))
      else $error("scan index beyond user count");

   a_pipe_in_query: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff || s2_valid_ff) |->
      (state_ff == cnfr_pkg::ST_SCAN || state_ff == cnfr_pkg::ST_DRAIN))
      else $error("scan pipeline busy outside a query");

   a_ok_has_pick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cnfr_pkg::ST_DRAIN && !s1_valid_ff && !s2_valid_ff) |-> have_d_ff)
      else $error("query finished without any candidate");

   a_finish_sends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cnfr_pkg::ST_FINISH && (!rsp_valid_ff || !rsp_stall)) |=>
      (rsp_valid_ff && state_ff == cnfr_pkg::ST_IDLE))
      else $error("finished result not moved to output");
`endif

endmodule

### tb/common_neighbor_friend_recommender_unit_tb.sv
// Testbench for the common-neighbor friend recommender: table-driven and random requests.
`timescale 1ns / 100ps

module common_neighbor_friend_recommender_unit_tb;

   localparam int SETTLE_CYCLES  = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SEGMENTS       = 10;
   localparam int SEGMENT_ITEMS  = 56;

   typedef enum bit {STEP_REQUEST, STEP_CONFIG} step_kind_type;

   typedef struct {
      step_kind_type                kind;
      cnfr_pkg::req_type            item;
      logic [cnfr_pkg::COUNT_W-1:0] count;
      bit                           typed;
      cnfr_pkg::rsp_type            typed_rsp;
   } step_type;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_valid   = 1'b0;
   logic                         req_stall;
   cnfr_pkg::req_type            req_payload = '0;
   logic                         rsp_valid;
   logic                         rsp_stall   = 1'b0;
   cnfr_pkg::rsp_type            rsp_payload;
   logic                         csr_valid   = 1'b0;
   logic                         csr_ready;
   logic [cnfr_pkg::COUNT_W-1:0] csr_data    = '0;

   // Shadow of the block's stores and register, updated on accepted requests and register writes.
   logic [cnfr_pkg::ROW_W-1:0]   adj_mem [cnfr_pkg::MAX_USERS];
   logic [cnfr_pkg::ID_W-1:0]    id_mem  [cnfr_pkg::MAX_USERS];
   logic [cnfr_pkg::COUNT_W-1:0] user_count_q = cnfr_pkg::COUNT_W'(64);

   cnfr_pkg::rsp_type expected_results [$];
   bit                pending_typed     = 1'b0;
   cnfr_pkg::rsp_type pending_typed_rsp = '0;

   int  error_count   = 0;
   int  quiet_cycles  = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  active_count  = 64;
   bit  accepted_any;

   step_type directed_steps [$];

   common_neighbor_friend_recommender_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   function automatic bit outranks(input int score, input logic [cnfr_pkg::ID_W-1:0] id,
                                   input int best_score,
                                   input logic [cnfr_pkg::ID_W-1:0] best_id,
                                   input bit have);
      if (!have) return 1'b1;
      if (score != best_score) return score > best_score;
      return id < best_id;
   endfunction

   function automatic cnfr_pkg::rsp_type recommend(
      input logic [cnfr_pkg::FIELD_IDX_W-1:0] q);
      int                         n, c, d, best_c, best_d;
      logic [cnfr_pkg::ROW_W-1:0] live, rowq, cand, rowi, drop;
      logic [cnfr_pkg::ID_W-1:0]  id_c, id_d;
      bit                         have_c, have_d;
      cnfr_pkg::rsp_type          r;
      n = (user_count_q > cnfr_pkg::COUNT_W'(cnfr_pkg::MAX_USERS)) ?
          cnfr_pkg::MAX_USERS : int'(user_count_q);
      have_c = 1'b0;
      have_d = 1'b0;
      best_c = 0;
      best_d = 0;
      id_c = '0;
      id_d = '0;
      r.status = cnfr_pkg::STATUS_RANGE;
      r.recommended_id = '0;
      if (int'(q) >= n) return r;
      live = (n >= cnfr_pkg::ROW_W) ? '1 : ((64'd1 << n) - 64'd1);
      rowq = adj_mem[q] & live;
      cand = ~rowq & live & ~(64'd1 << q);
      if (cand == '0) begin
         r.status = cnfr_pkg::STATUS_NONE;
         return r;
      end
      for (int i = 0; i < n; i++) begin
         if (cand[i]) begin
            drop = (64'd1 << i) | (64'd1 << q);
            rowi = adj_mem[i] & live;
            c = $countones(rowq & rowi & ~drop);
            d = $countones(rowi & ~(64'd1 << i));
            if (c > 0 && outranks(c, id_mem[i], best_c, id_c, have_c)) begin
               have_c = 1'b1;
               best_c = c;
               id_c = id_mem[i];
            end
            if (outranks(d, id_mem[i], best_d, id_d, have_d)) begin
               have_d = 1'b1;
               best_d = d;
               id_d = id_mem[i];
            end
         end
      end
      r.status = cnfr_pkg::STATUS_OK;
      r.recommended_id = have_c ? id_c : id_d;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Sample both channels and the register port at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         accepted_any = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            accepted_any = 1'b1;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result with no request pending: status %0d id %0d",
                                         rsp_payload.status, rsp_payload.recommended_id));
            end else begin
               cnfr_pkg::rsp_type exp_rsp;
               exp_rsp = expected_results.pop_front();
               if (rsp_payload.status != exp_rsp.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_payload.status, exp_rsp.status));
               if (rsp_payload.recommended_id != exp_rsp.recommended_id)
                  report_mismatch($sformatf("recommended_id %0d, expected %0d",
                                            rsp_payload.recommended_id,
                                            exp_rsp.recommended_id));
            end
         end
         if (req_valid && !req_stall) begin
            accepted_any = 1'b1;
            if (req_payload.opcode == cnfr_pkg::OP_LOAD) begin
               adj_mem[req_payload.user_index] = req_payload.adjacency_row;
               id_mem[req_payload.user_index]  = req_payload.user_id;
            end else begin
               expected_results.push_back(pending_typed ? pending_typed_rsp
                                                        : recommend(req_payload.user_index));
            end
         end
         if (csr_valid && csr_ready) begin
            accepted_any = 1'b1;
            user_count_q = csr_data;
         end
         quiet_cycles = accepted_any ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   task automatic send_request(input cnfr_pkg::req_type item, input bit typed,
                               input cnfr_pkg::rsp_type typed_rsp);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_payload       <= item;
      pending_typed     <= typed;
      pending_typed_rsp <= typed_rsp;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Hold requests until every result is back, then let the block go quiet.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_user_count(input logic [cnfr_pkg::COUNT_W-1:0] value);
      settle_block();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      active_count = (int'(value) > cnfr_pkg::MAX_USERS) ? cnfr_pkg::MAX_USERS : int'(value);
   endtask

   function automatic step_type cfg_step(input int value);
      step_type s;
      s = '{kind: STEP_CONFIG, default: '0};
      s.count = cnfr_pkg::COUNT_W'(value);
      return s;
   endfunction

   function automatic step_type load_step(input int idx,
                                          input logic [cnfr_pkg::ROW_W-1:0] row,
                                          input logic [cnfr_pkg::ID_W-1:0] id);
      step_type s;
      s = '{kind: STEP_REQUEST, default: '0};
      s.item.opcode        = cnfr_pkg::OP_LOAD;
      s.item.user_index    = cnfr_pkg::FIELD_IDX_W'(idx);
      s.item.adjacency_row = row;
      s.item.user_id       = id;
      return s;
   endfunction

   function automatic step_type query_step(input int idx);
      step_type s;
      s = '{kind: STEP_REQUEST, default: '0};
      s.item.opcode     = cnfr_pkg::OP_QUERY;
      s.item.user_index = cnfr_pkg::FIELD_IDX_W'(idx);
      return s;
   endfunction

   function automatic step_type query_expect(input int idx,
                                             input logic [cnfr_pkg::STATUS_W-1:0] status);
      step_type s;
      s = query_step(idx);
      s.typed = 1'b1;
      s.typed_rsp.status = status;
      s.typed_rsp.recommended_id = '0;
      return s;
   endfunction

   function automatic logic [cnfr_pkg::ROW_W-1:0] random_row();
      logic [cnfr_pkg::ROW_W-1:0] a, b, c;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      c = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: return a;
         1: return a & b;
         2: return a | b;
         default: return a & b & c;
      endcase
   endfunction

   function automatic cnfr_pkg::req_type random_request();
      cnfr_pkg::req_type r;
      r.opcode = $urandom_range(0, 1) ? cnfr_pkg::OP_QUERY : cnfr_pkg::OP_LOAD;
      if (active_count > 0 && $urandom_range(0, 9) != 0)
         r.user_index = cnfr_pkg::FIELD_IDX_W'($urandom_range(0, active_count - 1));
      else
         r.user_index = cnfr_pkg::FIELD_IDX_W'($urandom_range(0, cnfr_pkg::MAX_USERS - 1));
      r.adjacency_row = random_row();
      // Small IDs make ties common.
      r.user_id = $urandom_range(0, 1) ? cnfr_pkg::ID_W'($urandom_range(0, 7)) :
                                         cnfr_pkg::ID_W'($urandom);
      return r;
   endfunction

   function automatic int pick_count(input int phase, input int seg);
      if (phase == 0) begin
         case (seg)
            0: return 1;
            1: return 0;
            2: return 64;
            3: return 127;
            4: return 2;
            default: ;
         endcase
      end
      case ($urandom_range(0, 19))
         0, 1, 2:    return $urandom_range(64, 127);
         3, 4, 5:    return $urandom_range(9, 63);
         default:    return $urandom_range(2, 8);
      endcase
   endfunction

   initial begin
      cnfr_pkg::req_type item;
      directed_steps = '{
         cfg_step(4),
         load_step(0, 64'h2, 31'd100),
         load_step(1, 64'h5, 31'd200),
         load_step(2, 64'hA, 31'd50),
         load_step(3, 64'hFFFF_FFFF_FFFF_FFF4, 31'h7FFF_FFFF),
         load_step(4, '1, 31'd0),
         load_step(63, 64'h0, 31'h2AAA_AAAA),
         query_step(0),
         query_step(3),
         query_expect(4, cnfr_pkg::STATUS_RANGE),
         query_expect(63, cnfr_pkg::STATUS_RANGE),
         load_step(1, 64'hF, 31'd200),
         query_expect(1, cnfr_pkg::STATUS_NONE),
         query_step(2),
         cfg_step(0),
         query_expect(0, cnfr_pkg::STATUS_RANGE),
         cfg_step(1),
         query_expect(0, cnfr_pkg::STATUS_NONE),
         cfg_step(2),
         query_expect(0, cnfr_pkg::STATUS_NONE),
         query_expect(1, cnfr_pkg::STATUS_NONE),
         cfg_step(4),
         load_step(2, 64'h0, 31'd50),
         query_step(2),
         query_step(3)
      };

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_steps[k]) begin
         if (directed_steps[k].kind == STEP_CONFIG)
            write_user_count(directed_steps[k].count);
         else
            send_request(directed_steps[k].item, directed_steps[k].typed,
                         directed_steps[k].typed_rsp);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 27;
               recv_idle_pct = 84;
            end
            1: begin
               send_idle_pct = 84;
               recv_idle_pct = 27;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         // Fill every row before any query can reach past the directed users.
         if (phase == 0) begin
            for (int u = 0; u < cnfr_pkg::MAX_USERS; u++) begin
               item = random_request();
               item.opcode = cnfr_pkg::OP_LOAD;
               item.user_index = cnfr_pkg::FIELD_IDX_W'(u);
               send_request(item, 1'b0, '0);
            end
         end
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            write_user_count(cnfr_pkg::COUNT_W'(pick_count(phase, seg)));
            for (int j = 0; j < SEGMENT_ITEMS; j++) begin
               if ($urandom_range(0, 199) == 0) settle_block();
               send_request(random_request(), 1'b0, '0);
            end
         end
      end

      settle_block();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
